// ===== sv/ucdp_pkg.sv =====
package ucdp_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_CLASS    = 2'd0,
		REG_SUBCLASS = 2'd1,
		REG_PROTOCOL = 2'd2
	} reg_index_t;

	localparam logic [7:0] CLASS_RESET    = 8'h08;
	localparam logic [7:0] SUBCLASS_RESET = 8'h06;
	localparam logic [7:0] PROTOCOL_RESET = 8'h50;

	// descriptor type codes
	localparam logic [7:0] DESC_CONFIG   = 8'h02;
	localparam logic [7:0] DESC_IFACE    = 8'h04;
	localparam logic [7:0] DESC_ENDPOINT = 8'h05;

	localparam logic [1:0]  XFER_BULK       = 2'd2;
	localparam logic [3:0]  EP_NUM_MASK     = 4'hF;
	localparam logic [15:0] DEFAULT_PACKET  = 16'd512;
	localparam logic [16:0] WALK_START      = 17'd9;
	localparam logic [15:0] OFFSET_LIMIT    = 16'hFFFF;

	typedef struct packed {
		logic       matched;
		logic [4:0] out_endpoint;
		logic [4:0] in_endpoint;
		logic [15:0] max_packet;
	} result_t;

	typedef struct packed {
		logic [7:0] class_code;
		logic [7:0] subclass_code;
		logic [7:0] protocol_code;
	} codes_t;

endpackage

// ===== sv/ucdp_byte_if.sv =====
interface ucdp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ===== sv/ucdp_result_if.sv =====
interface ucdp_result_if;
	logic        valid;
	logic        ready;
	logic        matched;
	logic [4:0]  out_endpoint;
	logic [4:0]  in_endpoint;
	logic [15:0] max_packet;

	modport source (output valid, output matched, output out_endpoint,
		output in_endpoint, output max_packet, input ready);
	modport sink (input valid, input matched, input out_endpoint,
		input in_endpoint, input max_packet, output ready);
endinterface

// ===== sv/ucdp_parser.sv =====
module ucdp_parser
	import ucdp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  codes_t     want,
	output result_t    result
);

	typedef struct packed {
		logic [15:0] byte_offset;
		logic [15:0] total_length;
		logic        header_ok;
		logic [16:0] next_start;
		logic [15:0] desc_start;
		logic [7:0]  desc_length;
		logic [7:0]  desc_kind;
		logic        desc_active;
		logic        walk_stopped;
		codes_t      iface_codes;
		logic [7:0]  pending_ep_address;
		logic        pending_is_bulk;
		logic [7:0]  pending_size_low;
		logic [7:0]  bulk_out_address;
		logic [7:0]  bulk_in_address;
		logic [15:0] bulk_packet_size;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		byte_offset: 16'd0, total_length: 16'd0, header_ok: 1'b0,
		next_start: WALK_START, desc_start: 16'd0, desc_length: 8'd0,
		desc_kind: 8'd0, desc_active: 1'b0, walk_stopped: 1'b0,
		iface_codes: '0, pending_ep_address: 8'd0, pending_is_bulk: 1'b0,
		pending_size_low: 8'd0, bulk_out_address: 8'd0,
		bulk_in_address: 8'd0, bulk_packet_size: 16'd0
	};

	parse_state_t st_q;
	parse_state_t nxt;
	logic [15:0]  p;
	logic [15:0]  rel;

	always_comb begin
		nxt = st_q;
		p   = st_q.byte_offset;
		rel = p - st_q.desc_start;
		if (p != OFFSET_LIMIT) begin
			if (p == 16'd1) begin
				nxt.header_ok = (data_byte == DESC_CONFIG);
			end else if (p == 16'd2) begin
				nxt.total_length[7:0] = data_byte;
			end else if (p == 16'd3) begin
				nxt.total_length[15:8] = data_byte;
			end

			if (!st_q.walk_stopped && {1'b0, p} == st_q.next_start) begin
				// new descriptor header, only inside the total length
				if (({1'b0, p} + 17'd2) < {1'b0, nxt.total_length}) begin
					nxt.desc_start  = p;
					nxt.desc_length = data_byte;
					nxt.desc_kind   = 8'd0;
					if (data_byte == 8'd0) begin
						nxt.walk_stopped = 1'b1;
						nxt.desc_active  = 1'b0;
						nxt.header_ok    = 1'b0;
					end else begin
						nxt.desc_active = 1'b1;
						nxt.next_start  = {1'b0, p} + {9'd0, data_byte};
					end
				end else begin
					nxt.walk_stopped = 1'b1;
					nxt.desc_active  = 1'b0;
				end
			end else if (st_q.desc_active && p >= st_q.desc_start &&
					rel < {8'd0, st_q.desc_length}) begin
				if (rel == 16'd1) begin
					nxt.desc_kind = data_byte;
				end else if (st_q.desc_kind == DESC_IFACE) begin
					if (rel == 16'd5) begin
						nxt.iface_codes.class_code = data_byte;
					end else if (rel == 16'd6) begin
						nxt.iface_codes.subclass_code = data_byte;
					end else if (rel == 16'd7) begin
						nxt.iface_codes.protocol_code = data_byte;
					end
				end else if (st_q.desc_kind == DESC_ENDPOINT) begin
					if (rel == 16'd2) begin
						nxt.pending_ep_address = data_byte;
					end else if (rel == 16'd3) begin
						nxt.pending_is_bulk = (data_byte[1:0] == XFER_BULK);
					end else if (rel == 16'd4) begin
						nxt.pending_size_low = data_byte;
					end else if (rel == 16'd5 && st_q.pending_is_bulk) begin
						// direction bit picks the in or out slot
						if (st_q.pending_ep_address[7]) begin
							nxt.bulk_in_address = st_q.pending_ep_address;
						end else begin
							nxt.bulk_out_address = st_q.pending_ep_address;
						end
						nxt.bulk_packet_size = {data_byte, st_q.pending_size_low};
					end
				end
			end
			nxt.byte_offset = p + 16'd1;
		end
	end

	always_comb begin
		result = '0;
		if (nxt.header_ok && nxt.iface_codes == want &&
				nxt.bulk_out_address != 8'd0 && nxt.bulk_in_address != 8'd0) begin
			result.matched      = 1'b1;
			result.out_endpoint = {nxt.bulk_out_address[3:0] & EP_NUM_MASK, 1'b0};
			result.in_endpoint  = {nxt.bulk_in_address[3:0] & EP_NUM_MASK, 1'b1};
			result.max_packet   = (nxt.bulk_packet_size == 16'd0) ?
				DEFAULT_PACKET : nxt.bulk_packet_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (step) begin
			st_q <= last ? STATE_RESET : nxt;
		end
	end

endmodule

// ===== sv/usb_config_descriptor_parser_unit.sv =====
// USB configuration descriptor parser. Descriptor bytes enter on byte_in
// one request per byte, in block order; the byte flagged last yields one
// request on result_out telling whether the block carries an interface
// with the configured class/subclass/protocol codes plus a bulk IN and a
// bulk OUT endpoint, together with the host endpoint indices and the bulk
// max packet size (zero reported as 512). Each byte is registered, parsed
// by one level of compare-and-update logic and, when last, the result is
// registered in an output stage. A byte is taken every cycle; only a last
// byte that meets a full, stalled output stage holds the input. The user
// must write the class, subclass and protocol registers through cfg_wr_en/
// cfg_index/cfg_data only while no block is in flight, which the block
// does not enforce; they keep their values across blocks.
module usb_config_descriptor_parser_unit
	import ucdp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	ucdp_byte_if.sink     byte_in,
	ucdp_result_if.source result_out,
	input  logic          cfg_wr_en,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	// configured match codes
	codes_t codes_q;

	// input stage
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// output stage
	logic    valid_s2;
	result_t result_s2;

	result_t parse_result;
	logic    out_free;
	logic    fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '{CLASS_RESET, SUBCLASS_RESET, PROTOCOL_RESET};
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_CLASS:    codes_q.class_code    <= cfg_data;
				REG_SUBCLASS: codes_q.subclass_code <= cfg_data;
				REG_PROTOCOL: codes_q.protocol_code <= cfg_data;
				default:      ;
			endcase
		end
	end

	// only a last byte needs room in the output stage
	assign out_free      = !valid_s2 || result_out.ready;
	assign fire_s1       = valid_s1 && (!last_s1 || out_free);
	assign byte_in.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			data_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last;
		end
	end

	ucdp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire_s1),
		.data_byte (data_s1),
		.last      (last_s1),
		.want      (codes_q),
		.result    (parse_result)
	);

	// result register, loaded by a parsed last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			result_s2 <= parse_result;
		end
	end

	assign result_out.valid        = valid_s2;
	assign result_out.matched      = result_s2.matched;
	assign result_out.out_endpoint = result_s2.out_endpoint;
	assign result_out.in_endpoint  = result_s2.in_endpoint;
	assign result_out.max_packet   = result_s2.max_packet;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import ucdp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// endpoint address bit that marks the IN direction
	localparam logic [7:0] EP_DIR_IN = 8'h80;

	// stimulus sizing
	localparam int PHASE_BYTES      = 260;
	localparam int PHASE_BLOCKS     = 6;
	localparam int QUIET_LIMIT      = 2000;
	localparam int SETTLE_CYCLES    = 4;

	// smallest block that can match: header, 8-byte interface, two 6-byte endpoints;
	// endpoint number 15 both ways, sizes 0xffff then 0 so the 512 default shows up
	localparam logic [7:0] TIGHT_MATCH [29] = '{
		8'd9, 8'h02, 8'd29, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
		8'd8, 8'h04, 8'd0, 8'd0, 8'd2, 8'h08, 8'h06, 8'h50,
		8'd6, 8'h05, 8'h0F, 8'h02, 8'hFF, 8'hFF,
		8'd6, 8'h05, 8'h8F, 8'h02, 8'h00, 8'h00
	};

	// kinds of descriptor the block composer can lay down
	typedef enum int {
		PLAN_IFACE  = 0,
		PLAN_EP_IN  = 1,
		PLAN_EP_OUT = 2,
		PLAN_OTHER  = 3,
		PLAN_ZERO   = 4
	} plan_t;

	// tracks the parse of the block in flight and holds the reports still owed
	class bulk_match_tracker;
		codes_t      wanted;
		result_t     reports_due[$];
		int          errors;
		int          reports_checked;
		int          matches_seen;

		bit [15:0]   offset;
		bit [15:0]   total_len;
		bit          hdr_ok;
		bit [16:0]   walk_next;
		bit [15:0]   d_start;
		bit [7:0]    d_len;
		bit [7:0]    d_kind;
		bit          d_live;
		bit          walk_done;
		codes_t      seen_codes;
		bit [7:0]    ep_addr_pend;
		bit          pend_bulk;
		bit [7:0]    size_lo_pend;
		bit [7:0]    out_addr;
		bit [7:0]    in_addr;
		bit [15:0]   pkt_size;

		function new();
			wanted = {CLASS_RESET, SUBCLASS_RESET, PROTOCOL_RESET};
			restart();
		endfunction

		function void restart();
			offset = '0;
			total_len = '0;
			hdr_ok = 1'b0;
			walk_next = WALK_START;
			d_start = '0;
			d_len = '0;
			d_kind = '0;
			d_live = 1'b0;
			walk_done = 1'b0;
			seen_codes = '0;
			ep_addr_pend = '0;
			pend_bulk = 1'b0;
			size_lo_pend = '0;
			out_addr = '0;
			in_addr = '0;
			pkt_size = '0;
		endfunction

		function int due();
			return reports_due.size();
		endfunction

		// one byte inside the current descriptor, rel bytes past its start
		function void capture_field(bit [15:0] rel, bit [7:0] b);
			if (rel == 16'd1) begin
				d_kind = b;
				return;
			end
			if (d_kind == DESC_IFACE) begin
				case (rel)
					16'd5: seen_codes.class_code = b;
					16'd6: seen_codes.subclass_code = b;
					16'd7: seen_codes.protocol_code = b;
					default: ;
				endcase
			end else if (d_kind == DESC_ENDPOINT) begin
				case (rel)
					16'd2: ep_addr_pend = b;
					16'd3: pend_bulk = (b[1:0] == XFER_BULK);
					16'd4: size_lo_pend = b;
					16'd5: if (pend_bulk) begin
						if ((ep_addr_pend & EP_DIR_IN) != 8'd0)
							in_addr = ep_addr_pend;
						else
							out_addr = ep_addr_pend;
						pkt_size = {b, size_lo_pend};
					end
					default: ;
				endcase
			end
		endfunction

		function void absorb_byte(bit [7:0] b, bit fin);
			bit [16:0] here;
			result_t   want;
			if (offset < OFFSET_LIMIT) begin
				here = {1'b0, offset};
				if (offset == 16'd1)
					hdr_ok = (b == DESC_CONFIG);
				else if (offset == 16'd2)
					total_len[7:0] = b;
				else if (offset == 16'd3)
					total_len[15:8] = b;

				if (!walk_done && here == walk_next) begin
					if (here + 17'd2 < {1'b0, total_len}) begin
						d_start = offset;
						d_len = b;
						d_kind = '0;
						if (b == 8'd0) begin
							// zero length would loop forever: stop and refuse the match
							walk_done = 1'b1;
							d_live = 1'b0;
							hdr_ok = 1'b0;
						end else begin
							d_live = 1'b1;
							walk_next = here + {9'd0, b};
						end
					end else begin
						walk_done = 1'b1;
						d_live = 1'b0;
					end
				end else if (d_live && offset >= d_start) begin
					if (offset - d_start < {8'd0, d_len})
						capture_field(offset - d_start, b);
				end
				offset = offset + 16'd1;
			end
			if (!fin)
				return;

			want = '0;
			if (hdr_ok && seen_codes == wanted && out_addr != 8'd0 && in_addr != 8'd0) begin
				want.matched = 1'b1;
				want.out_endpoint = {out_addr[3:0] & EP_NUM_MASK, 1'b0};
				want.in_endpoint = {in_addr[3:0] & EP_NUM_MASK, 1'b1};
				want.max_packet = (pkt_size != 16'd0) ? pkt_size : DEFAULT_PACKET;
			end
			reports_due.push_back(want);
			restart();
		endfunction

		function void compare_report(bit m, bit [4:0] oe, bit [4:0] ie, bit [15:0] mp);
			result_t want;
			reports_checked++;
			if (reports_due.size() == 0) begin
				$display("%0t: report with none awaited: matched=%0d out=%0d in=%0d size=%0d",
					$time, m, oe, ie, mp);
				errors++;
				return;
			end
			want = reports_due.pop_front();
			if (want.matched)
				matches_seen++;
			if (want.matched != m) begin
				$display("%0t: matched expected %0d got %0d", $time, want.matched, m);
				errors++;
			end
			if (want.out_endpoint != oe) begin
				$display("%0t: out_endpoint expected %0d got %0d", $time, want.out_endpoint, oe);
				errors++;
			end
			if (want.in_endpoint != ie) begin
				$display("%0t: in_endpoint expected %0d got %0d", $time, want.in_endpoint, ie);
				errors++;
			end
			if (want.max_packet != mp) begin
				$display("%0t: max_packet expected %0d got %0d", $time, want.max_packet, mp);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	ucdp_byte_if   byte_if ();
	ucdp_result_if res_if ();

	usb_config_descriptor_parser_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_if),
		.result_out (res_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	bulk_match_tracker tracker;
	bit [7:0] block_bytes[$];
	int       tx_idle_pct;
	int       rx_idle_pct;
	int       bytes_sent;
	int       blocks_sent;
	int       pauses_taken;
	int       quiet_cycles;

	always #2 clk = ~clk;

	// result side: ready drops at random, rate set per phase
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// every accepted report is checked against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			tracker.compare_report(res_if.matched, res_if.out_endpoint,
				res_if.in_endpoint, res_if.max_packet);
	end

	// watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no request moved for %0d cycles, %0d reports still owed",
				$time, QUIET_LIMIT, tracker.due());
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic bit [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	// mostly the configured code, sometimes anything
	function automatic bit [7:0] near_code(bit [7:0] code);
		return ($urandom_range(0, 99) < 85) ? code : rand_byte();
	endfunction

	// lay down one descriptor block in block_bytes: mostly a well-formed
	// header + interface + bulk pair with random content, the rest noise,
	// short or zero-length descriptors, bad lengths, junk tails, truncation
	function automatic void compose_block();
		plan_t     plan[$];
		int        shape;
		int        cut;
		bit [15:0] tot;
		bit [15:0] size;
		bit [7:0]  addr;
		bit [7:0]  attr;
		bit [7:0]  desc_len;
		block_bytes.delete();
		shape = $urandom_range(0, 99);

		// pure noise block
		if (shape < 8) begin
			repeat ($urandom_range(1, 40)) block_bytes.push_back(rand_byte());
			return;
		end

		// configuration header, total length patched in below
		block_bytes.push_back(8'd9);
		block_bytes.push_back(($urandom_range(0, 99) < 93) ? DESC_CONFIG : rand_byte());
		repeat (7) block_bytes.push_back(rand_byte());

		if (shape < 70) begin
			if ($urandom_range(0, 3) == 0)
				plan.push_back(PLAN_OTHER);
			plan.push_back(PLAN_IFACE);
			if ($urandom_range(0, 1) == 1) begin
				plan.push_back(PLAN_EP_IN);
				plan.push_back(PLAN_EP_OUT);
			end else begin
				plan.push_back(PLAN_EP_OUT);
				plan.push_back(PLAN_EP_IN);
			end
			if ($urandom_range(0, 3) == 0)
				plan.push_back(plan_t'($urandom_range(0, 3)));
			// a zero length before or after the useful part
			if ($urandom_range(0, 99) < 6) begin
				if ($urandom_range(0, 1) == 1)
					plan.push_front(PLAN_ZERO);
				else
					plan.push_back(PLAN_ZERO);
			end
		end else begin
			repeat ($urandom_range(1, 6)) plan.push_back(plan_t'($urandom_range(0, 4)));
		end

		foreach (plan[k]) begin
			case (plan[k])
				PLAN_IFACE: begin
					// occasionally a length byte that cuts the interface short
					desc_len = ($urandom_range(0, 99) < 7) ? 8'($urandom_range(1, 8)) : 8'd9;
					block_bytes.push_back(desc_len);
					block_bytes.push_back(DESC_IFACE);
					repeat (3) block_bytes.push_back(rand_byte());
					block_bytes.push_back(near_code(tracker.wanted.class_code));
					block_bytes.push_back(near_code(tracker.wanted.subclass_code));
					block_bytes.push_back(near_code(tracker.wanted.protocol_code));
					block_bytes.push_back(rand_byte());
				end
				PLAN_EP_IN, PLAN_EP_OUT: begin
					desc_len = ($urandom_range(0, 99) < 7) ? 8'($urandom_range(1, 6)) : 8'd7;
					addr = {plan[k] == PLAN_EP_IN,
						($urandom_range(0, 99) < 85) ? 3'd0 : 3'($urandom), 4'($urandom)};
					attr = ($urandom_range(0, 99) < 80) ? {6'($urandom), XFER_BULK} : rand_byte();
					case ($urandom_range(0, 3))
						0: size = 16'd0;
						1: size = 16'd64;
						2: size = 16'd512;
						default: size = 16'($urandom);
					endcase
					block_bytes.push_back(desc_len);
					block_bytes.push_back(DESC_ENDPOINT);
					block_bytes.push_back(addr);
					block_bytes.push_back(attr);
					block_bytes.push_back(size[7:0]);
					block_bytes.push_back(size[15:8]);
					block_bytes.push_back(rand_byte());
				end
				PLAN_OTHER: begin
					desc_len = 8'($urandom_range(1, 12));
					block_bytes.push_back(desc_len);
					repeat (int'(desc_len) - 1) block_bytes.push_back(rand_byte());
				end
				default: begin
					block_bytes.push_back(8'd0);
					repeat ($urandom_range(0, 6)) block_bytes.push_back(rand_byte());
				end
			endcase
		end

		// total length: usually honest, sometimes short, tiny or wild
		tot = 16'(block_bytes.size());
		case ($urandom_range(0, 9))
			0: tot = 16'($urandom_range(0, 40));
			1: tot = tot - 16'($urandom_range(1, 8));
			2: tot = 16'($urandom);
			default: ;
		endcase
		block_bytes[2] = tot[7:0];
		block_bytes[3] = tot[15:8];

		if ($urandom_range(0, 99) < 10)
			repeat ($urandom_range(1, 8)) block_bytes.push_back(rand_byte());
		if ($urandom_range(0, 99) < 10) begin
			cut = $urandom_range(1, block_bytes.size());
			while (block_bytes.size() > cut) block_bytes.pop_back();
		end
	endfunction

	// one byte request; valid stays up into the next byte unless the sender idles
	task automatic send_byte(input bit [7:0] b, input bit fin);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			byte_if.valid <= 1'b0;
			@(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		byte_if.last <= fin;
		@(posedge clk);
		while (!byte_if.ready) @(posedge clk);
		tracker.absorb_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_block();
		foreach (block_bytes[k]) send_byte(block_bytes[k], k == block_bytes.size() - 1);
		blocks_sent++;
	endtask

	// sender stays off until every owed report is back
	task automatic hold_until_drained();
		byte_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.due() != 0) @(posedge clk);
	endtask

	// new codes and idle rates, then random blocks until the phase is full
	task automatic run_phase(input int tx_pct, input int rx_pct, input codes_t codes);
		int start_bytes;
		int start_blocks;
		// block idle: drained, plus the pipeline depth for trailing bytes
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_CLASS;
		cfg_data <= codes.class_code;
		@(posedge clk);
		cfg_index <= REG_SUBCLASS;
		cfg_data <= codes.subclass_code;
		@(posedge clk);
		cfg_index <= REG_PROTOCOL;
		cfg_data <= codes.protocol_code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.wanted = codes;

		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start_bytes = bytes_sent;
		start_blocks = blocks_sent;
		while (bytes_sent - start_bytes < PHASE_BYTES || blocks_sent - start_blocks < PHASE_BLOCKS) begin
			compose_block();
			// at least one drain pause per phase, more at random
			if (blocks_sent == start_blocks + 2 || $urandom_range(0, 99) < 8) begin
				hold_until_drained();
				pauses_taken++;
			end
			send_block();
		end
	endtask

	initial begin
		codes_t rnd_codes;
		// every input known from time zero
		byte_if.valid = 1'b0;
		byte_if.data_byte = 8'd0;
		byte_if.last = 1'b0;
		res_if.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_CLASS;
		cfg_data = 8'd0;
		tx_idle_pct = 27;
		rx_idle_pct = 74;
		bytes_sent = 0;
		blocks_sent = 0;
		pauses_taken = 0;
		quiet_cycles = 0;
		tracker = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tightest matching block at reset codes, then a one-byte block
		foreach (TIGHT_MATCH[k]) block_bytes.push_back(TIGHT_MATCH[k]);
		send_block();
		block_bytes.delete();
		block_bytes.push_back(8'hFF);
		send_block();

		// random phases: all-zero codes, all-ones codes, random codes
		run_phase(27, 74, '0);
		run_phase(74, 27, '1);
		rnd_codes = codes_t'($urandom_range(0, 32'hFF_FFFF));
		run_phase(0, 0, rnd_codes);

		// wrap up: everything back, then a settle wait for stragglers
		hold_until_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d blocks / %0d bytes, %0d reports checked, %0d of them matches",
			blocks_sent, bytes_sent, tracker.reports_checked, tracker.matches_seen);
		$display("codes reset, all-zero, all-ones and random; %0d drain pauses",
			pauses_taken);
		if (tracker.errors == 0 && tracker.due() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
